// File: design/fp32_sin_cos_unit_defines.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef FP32_SIN_COS_UNIT_DEFINES_SVH
`define FP32_SIN_COS_UNIT_DEFINES_SVH

// same-cycle implication
`define FP32SC_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fp32 sin/cos check failed");

// next-cycle implication
`define FP32SC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fp32 sin/cos check failed");

`endif

// File: design/fp32sc_pkg.sv
// types, constants and binary32 arithmetic functions of the sin/cos pipeline
// no dependencies
package fp32sc_pkg;

    localparam int NumStages = 23;

    typedef logic [4:0] stage_idx_t;

    typedef enum logic [1:0] {
        CVT_RINT,
        CVT_ROUND,
        CVT_FLOOR
    } cvt_mode_t;

    typedef struct packed {
        logic        cosf;
        logic [31:0] x;
        logic [31:0] s;
        logic [31:0] ki;
        logic [31:0] k;
        logic [31:0] t;
        logic [31:0] m;
        logic [31:0] hk;
        logic [31:0] fli;
        logic [31:0] fl;
        logic [31:0] b;
        logic [31:0] sg;
        logic [31:0] t2;
        logic [31:0] p;
    } sc_word_t;

    localparam logic [31:0] C_INV_PI = 32'h3EA2F983;
    localparam logic [31:0] C_PI_A   = 32'h40490000;
    localparam logic [31:0] C_PI_B   = 32'h3A7D8000;
    localparam logic [31:0] C_PI_C   = 32'h35288000;
    localparam logic [31:0] C_PI_D   = 32'h2F05C000;
    localparam logic [31:0] C_PI_E   = 32'hA9E7B968;
    localparam logic [31:0] C_HPI_HI = 32'h3FC90FDB;
    localparam logic [31:0] C_HPI_LO = 32'hB33BBD2E;
    localparam logic [31:0] C_Q0     = 32'h362ED04C;
    localparam logic [31:0] C_Q1     = 32'hB94FB63B;
    localparam logic [31:0] C_Q2     = 32'h3C088758;
    localparam logic [31:0] C_Q3     = 32'hBE2AAAA5;
    localparam logic [31:0] C_HALF   = 32'h3F000000;
    localparam logic [31:0] C_ONE    = 32'h3F800000;
    localparam logic [31:0] C_FOUR   = 32'h40800000;
    localparam logic [31:0] C_MTWO   = 32'hC0000000;
    localparam logic [31:0] C_QNAN   = 32'h7FC00000;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic logic [5:0] clz50(input logic [49:0] m);
        logic [5:0] n;
        logic       hit;
        n   = 6'd0;
        hit = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!hit && m[i]) begin
                hit = 1'b1;
                n   = 6'(49 - i);
            end
        end
        return n;
    endfunction

    // value = m / 2^47 * 2^(e - 127), rounded to nearest even
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                            input logic [49:0] m);
        logic [5:0]         lz;
        logic [49:0]        mn;
        logic [49:0]        mt;
        logic signed [11:0] en;
        logic [11:0]        sh;
        logic               lost;
        logic [30:0]        base;
        logic               rnd;
        lz   = clz50(m);
        mn   = m << lz;
        en   = e + 12'sd2 - $signed({6'd0, lz});
        lost = 1'b0;
        mt   = mn;
        if (en < 12'sd1) begin
            sh = 12'(12'sd1 - en);
            if (sh >= 12'd50) begin
                mt   = 50'd0;
                lost = 1'b1;
            end else begin
                mt   = mn >> sh;
                lost = (mn << (12'd50 - sh)) != 50'd0;
            end
        end
        if (en >= 12'sd1)
            base = {en[7:0], mt[48:26]};
        else
            base = {8'd0, mt[48:26]};
        rnd = mt[25] & ((|mt[24:0]) | lost | mt[26]);
        if (m == 50'd0)
            return {s, 31'd0};
        else if (en >= 12'sd255)
            return {s, 8'hFF, 23'd0};
        else
            return {s, base + {30'd0, rnd}};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sr;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        pr;
        logic signed [11:0] e;
        sr = a[31] ^ b[31];
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        pr = ma * mb;
        e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            return C_QNAN;
        else if (is_inf(a) || is_inf(b))
            return {sr, 8'hFF, 23'd0};
        else
            return fp_pack(sr, e, {2'd0, pr});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  eh;
        logic [7:0]  el;
        logic [7:0]  d;
        logic [49:0] ah;
        logic [49:0] bl;
        logic [49:0] bs;
        logic [49:0] m;
        logic        sr;
        if (a[30:0] >= b[30:0]) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        eh = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        el = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        d  = eh - el;
        ah = {1'b0, hi[30:23] != 8'd0, hi[22:0], 25'd0};
        bl = {1'b0, lo[30:23] != 8'd0, lo[22:0], 25'd0};
        if (d >= 8'd50)
            bs = {49'd0, bl != 50'd0};
        else
            bs = (bl >> d) | {49'd0, (bl << (8'd50 - d)) != 50'd0};
        if (hi[31] == lo[31])
            m = ah + bs;
        else
            m = ah - bs;
        sr = (hi[31] != lo[31] && m == 50'd0) ? 1'b0 : hi[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
            return C_QNAN;
        else if (is_inf(hi))
            return hi;
        else
            return fp_pack(sr, $signed({4'd0, eh}) - 12'sd1, m);
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        return fp_add(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic [31:0] fp_to_int(input logic [31:0] v, input cvt_mode_t mode);
        logic [7:0]  e;
        logic [23:0] m;
        logic [31:0] q;
        logic [55:0] w;
        logic [55:0] w2;
        logic [7:0]  sh;
        logic        half;
        logic        rest;
        logic        inc;
        logic [31:0] qq;
        e    = v[30:23];
        m    = {e != 8'd0, v[22:0]};
        w    = {m, 32'd0};
        half = 1'b0;
        rest = 1'b0;
        sh   = 8'd150 - e;
        q    = 32'd0;
        if (e >= 8'd150) begin
            q = {8'd0, m} << (e - 8'd150);
        end else if (sh <= 8'd55) begin
            w2   = w >> sh;
            q    = {8'd0, w2[55:32]};
            half = w2[31];
            rest = (|w2[30:0]) | ((w << (8'd56 - sh)) != 56'd0);
        end else begin
            rest = m != 24'd0;
        end
        unique case (mode)
            CVT_ROUND: inc = half;
            CVT_RINT:  inc = half & (rest | q[0]);
            CVT_FLOOR: inc = v[31] & (half | rest);
            default:   inc = 1'b0;
        endcase
        qq = q + {31'd0, inc};
        if (is_nan(v))
            return 32'd0;
        else if (e >= 8'd158)
            return v[31] ? 32'h80000000 : 32'h7FFFFFFF;
        else
            return v[31] ? (~qq + 32'd1) : qq;
    endfunction

    function automatic logic [31:0] int_to_fp(input logic [31:0] i);
        logic [31:0] mag;
        mag = i[31] ? (~i + 32'd1) : i;
        return fp_pack(i[31], 12'sd174, {18'd0, mag});
    endfunction

    function automatic sc_word_t stage_op(input stage_idx_t idx, input sc_word_t d);
        sc_word_t r;
        r = d;
        unique case (idx)
            5'd0:  r.s = fp_mul(d.x, C_INV_PI);
            5'd1:  if (d.cosf) r.s = fp_add(d.s, C_HALF);
            5'd2:  r.ki = fp_to_int(d.s, d.cosf ? CVT_RINT : CVT_ROUND);
            5'd3:  r.k = int_to_fp(d.ki);
            5'd4:
            begin
                r.m  = fp_mul(d.k, C_PI_A);
                r.hk = fp_mul(d.k, C_HALF);
                r.b  = fp_mul(d.k, C_MTWO);
            end
            5'd5:
            begin
                r.t   = fp_sub(d.x, d.m);
                r.m   = fp_mul(d.k, C_PI_B);
                r.fli = fp_to_int(d.hk, CVT_FLOOR);
            end
            5'd6:
            begin
                r.t  = fp_sub(d.t, d.m);
                r.fl = int_to_fp(d.fli);
            end
            5'd7:
            begin
                if (d.cosf) r.t = fp_add(d.t, C_HPI_HI);
                r.m  = fp_mul(d.k, C_PI_C);
                r.fl = fp_mul(d.fl, C_FOUR);
            end
            5'd8:
            begin
                r.t  = fp_sub(d.t, d.m);
                r.m  = fp_mul(d.k, C_PI_D);
                r.sg = fp_add(d.fl, d.b);
            end
            5'd9:
            begin
                r.t  = fp_sub(d.t, d.m);
                r.m  = fp_mul(d.k, C_PI_E);
                r.sg = fp_add(d.sg, C_ONE);
            end
            5'd10: r.t = fp_sub(d.t, d.m);
            5'd11: if (d.cosf) r.t = fp_add(d.t, C_HPI_LO);
            5'd12: r.t2 = fp_mul(d.t, d.t);
            5'd13: r.p = fp_mul(d.t2, C_Q0);
            5'd14: r.p = fp_add(d.p, C_Q1);
            5'd15: r.p = fp_mul(d.p, d.t2);
            5'd16: r.p = fp_add(d.p, C_Q2);
            5'd17: r.p = fp_mul(d.p, d.t2);
            5'd18: r.p = fp_add(d.p, C_Q3);
            5'd19: r.p = fp_mul(d.p, d.t2);
            5'd20: r.p = fp_add(d.p, C_ONE);
            5'd21: r.p = fp_mul(d.t, d.p);
            5'd22: r.p = fp_mul(d.sg, d.p);
            default: r = d;
        endcase
        return r;
    endfunction

endpackage

// File: design/fp32_sin_cos_unit.sv
// Single-precision sine/cosine unit. One word enters per clock; the pipeline has 23 register
// stages, each applying one step of binary32 multiplies, adds or conversions. The last
// stage is the output register, and the whole pipeline halts while a result waits for
// result_ready, so sustained rate is one word per cycle whenever the consumer keeps up.
// NaN results are canonical.
// depends on fp32sc_pkg and fp32sc_stage
module fp32_sin_cos_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operand_valid,
    output logic        operand_ready,
    input  logic        action,
    input  logic [31:0] operand_bits,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] result_bits
);
    import fp32sc_pkg::*;

    logic     advance;
    logic     vld [NumStages+1];
    sc_word_t wrd [NumStages+1];
    sc_word_t last_word;

    assign advance = !vld[NumStages] || result_ready;

    always_comb
    begin
        wrd[0]      = '0;
        wrd[0].cosf = action;
        wrd[0].x    = operand_bits;
    end

    assign vld[0] = operand_valid;

    for (genvar i = 0; i < NumStages; i++)
    begin : g_stage
        fp32sc_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .op_sel   (stage_idx_t'(i)),
            .up_valid (vld[i]),
            .up_word  (wrd[i]),
            .dn_valid (vld[i+1]),
            .dn_word  (wrd[i+1])
        );
    end

    assign last_word     = wrd[NumStages];
    assign operand_ready = advance;
    assign result_valid  = vld[NumStages];
    assign result_bits   = is_nan(last_word.p) ? C_QNAN : last_word.p;

endmodule

// File: design/fp32sc_stage.sv
// one register stage of the sin/cos pipeline: applies one step and holds the word
// depends on fp32sc_pkg
module fp32sc_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  fp32sc_pkg::stage_idx_t op_sel,
    input  logic                  up_valid,
    input  fp32sc_pkg::sc_word_t  up_word,
    output logic                  dn_valid,
    output fp32sc_pkg::sc_word_t  dn_word
);
    import fp32sc_pkg::*;

    logic     valid_reg;
    sc_word_t word_reg;
    sc_word_t word_next;

    assign word_next = stage_op(op_sel, up_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// File: design/fp32sc_checker.sv
// port-level checks of the sin/cos unit, bound to the top level
// depends on fp32_sin_cos_unit_defines.svh and fp32_sin_cos_unit
`include "fp32_sin_cos_unit_defines.svh"

module fp32sc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        operand_valid,
    input logic        operand_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] result_bits
);

    logic result_is_nan;

    assign result_is_nan = (&result_bits[30:23]) && (|result_bits[22:0]);

    `FP32SC_CHECK(a_ready_when_empty, !result_valid, operand_ready)
    `FP32SC_CHECK(a_ready_follows_out, result_valid, operand_ready == result_ready)
    `FP32SC_CHECK(a_nan_canonical, result_valid && result_is_nan, result_bits == 32'h7FC00000)
    `FP32SC_CHECK_NEXT(a_hold_stalled, result_valid && !result_ready, result_valid && $stable(result_bits))
    `FP32SC_CHECK_NEXT(a_no_stall_loss, operand_valid && !operand_ready, result_valid)

endmodule

bind fp32_sin_cos_unit fp32sc_checker u_fp32sc_checker (.*);

// File: dv/testbench.sv
// self-checking testbench for fp32_sin_cos_unit: directed and random angles, sine and cosine
// expected words come from a bit-exact binary32 model of the reduction and polynomial below
// depends on fp32sc_pkg (conversion modes and constants) and the design sources
module testbench;
    import fp32sc_pkg::*;

    localparam logic ACT_SIN = 1'b0;
    localparam logic ACT_COS = 1'b1;
    localparam int STALL_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        operand_valid;
    logic        operand_ready;
    logic        action;
    logic [31:0] operand_bits;
    logic        result_valid;
    logic        result_ready;
    logic [31:0] result_bits;

    logic [31:0] result_q[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    int          words_sent;
    int          words_checked;
    int          quiet_cycles;

    fp32_sin_cos_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .operand_valid(operand_valid),
        .operand_ready(operand_ready),
        .action       (action),
        .operand_bits (operand_bits),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_bits  (result_bits)
    );

    // ---------------- binary32 arithmetic ----------------

    function automatic logic [31:0] round_single(input logic sgn, input logic [127:0] mag,
                                                 input int ex);
        int           msb;
        int           lsb_exp;
        int           sh;
        int           be;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] halfv;
        logic         up;
        if (mag == 128'd0)
            return {sgn, 31'd0};
        msb = 0;
        for (int i = 0; i < 128; i++)
            if (mag[i])
                msb = i;
        lsb_exp = msb + ex - 23;
        if (lsb_exp < -149)
            lsb_exp = -149;
        sh = lsb_exp - ex;
        up = 1'b0;
        if (sh <= 0) begin
            q = mag << (-sh);
        end else if (sh > 127) begin
            q = 128'd0;
        end else begin
            q     = mag >> sh;
            rem   = mag & ((128'd1 << sh) - 128'd1);
            halfv = 128'd1 << (sh - 1);
            up    = (rem > halfv) || (rem == halfv && q[0]);
        end
        q = q + {127'd0, up};
        if (q[24]) begin
            q = q >> 1;
            lsb_exp++;
        end
        if (q[23]) begin
            be = lsb_exp + 150;
            if (be >= 255)
                return {sgn, 8'hFF, 23'd0};
            return {sgn, be[7:0], q[22:0]};
        end
        return {sgn, 8'd0, q[22:0]};
    endfunction

    function automatic logic f_nan(input logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 23'd0;
    endfunction

    function automatic logic f_inf(input logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == 23'd0;
    endfunction

    function automatic logic [23:0] f_sig(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
    endfunction

    function automatic int f_exp(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? -149 : int'(v[30:23]) - 150;
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        logic [47:0] pr;
        sgn = a[31] ^ b[31];
        pr  = f_sig(a) * f_sig(b);
        if (f_nan(a) || f_nan(b))
            return C_QNAN;
        if ((f_inf(a) && b[30:0] == 31'd0) || (f_inf(b) && a[30:0] == 31'd0))
            return C_QNAN;
        if (f_inf(a) || f_inf(b))
            return {sgn, 8'hFF, 23'd0};
        return round_single(sgn, {80'd0, pr}, f_exp(a) + f_exp(b));
    endfunction

    function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  big;
        logic [31:0]  sml;
        logic [127:0] vb;
        logic [127:0] vs;
        logic [127:0] sum;
        int           d;
        if (f_nan(a) || f_nan(b))
            return C_QNAN;
        if (f_inf(a) && f_inf(b))
            return (a[31] == b[31]) ? a : C_QNAN;
        if (f_inf(a))
            return a;
        if (f_inf(b))
            return b;
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        d = f_exp(big) - f_exp(sml);
        if (d > 40)
            return big;
        vb  = {104'd0, f_sig(big)} << d;
        vs  = {104'd0, f_sig(sml)};
        sum = (big[31] == sml[31]) ? vb + vs : vb - vs;
        if (sum == 128'd0)
            return {big[31] & sml[31], 31'd0};
        return round_single(big[31], sum, f_exp(sml));
    endfunction

    function automatic logic [31:0] sub32(input logic [31:0] a, input logic [31:0] b);
        return add32(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic [31:0] to_int32(input logic [31:0] v, input cvt_mode_t md);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] halfv;
        logic        gt;
        logic        eq;
        logic        nz;
        logic        inc;
        int          ex;
        if (f_nan(v))
            return 32'd0;
        if (v[30:0] >= 31'h4F000000)
            return v[31] ? 32'h80000000 : 32'h7FFFFFFF;
        m  = {40'd0, f_sig(v)};
        ex = f_exp(v);
        gt = 1'b0;
        eq = 1'b0;
        nz = 1'b0;
        if (ex >= 0) begin
            q = m << ex;
        end else if (ex < -40) begin
            q  = 64'd0;
            nz = m != 64'd0;
        end else begin
            q     = m >> (-ex);
            rem   = m & ((64'd1 << (-ex)) - 64'd1);
            halfv = 64'd1 << (-ex - 1);
            gt    = rem > halfv;
            eq    = rem == halfv;
            nz    = rem != 64'd0;
        end
        case (md)
            CVT_ROUND: inc = gt | eq;
            CVT_RINT:  inc = gt | (eq & q[0]);
            default:   inc = v[31] & nz;
        endcase
        q = q + {63'd0, inc};
        return v[31] ? 32'(-q) : q[31:0];
    endfunction

    function automatic logic [31:0] from_int32(input logic [31:0] i);
        logic [31:0] mag;
        mag = i[31] ? (~i + 32'd1) : i;
        return round_single(i[31], {96'd0, mag}, 0);
    endfunction

    function automatic logic [31:0] sin_cos_value(input logic act, input logic [31:0] x);
        logic        is_cos;
        logic [31:0] s;
        logic [31:0] k;
        logic [31:0] t;
        logic [31:0] sg;
        logic [31:0] t2;
        logic [31:0] p;
        logic [31:0] res;
        is_cos = act == ACT_COS;
        s = mul32(x, C_INV_PI);
        if (is_cos)
            s = add32(s, C_HALF);
        k = from_int32(to_int32(s, is_cos ? CVT_RINT : CVT_ROUND));
        t = sub32(x, mul32(k, C_PI_A));
        t = sub32(t, mul32(k, C_PI_B));
        if (is_cos)
            t = add32(t, C_HPI_HI);
        t = sub32(t, mul32(k, C_PI_C));
        t = sub32(t, mul32(k, C_PI_D));
        t = sub32(t, mul32(k, C_PI_E));
        if (is_cos)
            t = add32(t, C_HPI_LO);
        sg = mul32(from_int32(to_int32(mul32(k, C_HALF), CVT_FLOOR)), C_FOUR);
        sg = add32(add32(sg, mul32(k, C_MTWO)), C_ONE);
        t2 = mul32(t, t);
        p  = add32(mul32(t2, C_Q0), C_Q1);
        p  = add32(mul32(p, t2), C_Q2);
        p  = add32(mul32(p, t2), C_Q3);
        p  = add32(mul32(p, t2), C_ONE);
        res = mul32(sg, mul32(t, p));
        return f_nan(res) ? C_QNAN : res;
    endfunction

    // ---------------- clock, reset, watchdog ----------------

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        rst_n          = 1'b0;
        operand_valid  = 1'b0;
        action         = ACT_SIN;
        operand_bits   = 32'd0;
        result_ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        words_sent     = 0;
        words_checked  = 0;
        quiet_cycles   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if ((operand_valid && operand_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("fp32_sin_cos_unit: mismatch");
            $finish;
        end
    end

    // ---------------- result side ----------------

    always @(negedge clk)
        if (rst_n)
            result_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n && result_valid && result_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected word: result_bits actual %h", result_bits);
                fail_count++;
            end else begin
                want = result_q.pop_front();
                if (result_bits !== want) begin
                    $error("result_bits expected %h actual %h", want, result_bits);
                    fail_count++;
                end
            end
            words_checked++;
        end
    end

    // ---------------- operand side ----------------

    task automatic send_word(input logic act, input logic [31:0] x);
        if ($urandom_range(99) < send_idle_pct) begin
            operand_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        operand_valid <= 1'b1;
        action        <= act;
        operand_bits  <= x;
        do
            @(posedge clk);
        while (!operand_ready);
        result_q.push_back(sin_cos_value(act, x));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender();
        operand_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_angle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return {1'($urandom), 8'($urandom_range(133, 100)), 23'($urandom)};
        else if (sel < 85)
            return $urandom;
        else if (sel < 95)
            return {1'($urandom), 8'($urandom_range(165, 145)), 23'($urandom)};
        else
            return {1'($urandom), 8'hFF, ($urandom_range(1) == 0) ? 23'd0 : 23'($urandom)};
    endfunction

    // ---------------- tests ----------------

    task automatic test_special_operands();
        logic [31:0] vals[12];
        vals = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                 32'h7FC00000, 32'hFF812345, 32'h00000001, 32'h807FFFFF,
                 32'h7F7FFFFF, 32'h40490FDB, 32'hC096CBE4, 32'h4F000000};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (vals[i]) begin
            send_word(ACT_SIN, vals[i]);
            send_word(ACT_COS, vals[i]);
        end
        send_word(ACT_COS, 32'h3FC90FDB);
        pause_sender();
    endtask

    task automatic test_random_angles(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            send_word(1'($urandom), random_angle());
        pause_sender();
    endtask

    task automatic test_drain_then_resume();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int i = 0; i < 20; i++)
            send_word(1'($urandom), random_angle());
        pause_sender();
        wait (result_q.size() == 0);
        @(negedge clk);
        for (int i = 0; i < 20; i++)
            send_word(1'($urandom), random_angle());
        pause_sender();
    endtask

    initial begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        test_special_operands();
        test_random_angles(0, 0, 450);
        test_random_angles(55, 0, 450);
        test_drain_then_resume();
        test_random_angles(0, 55, 450);
        test_random_angles(21, 21, 450);
        recv_stall_pct = 0;
        wait (result_q.size() == 0);
        repeat (40) @(posedge clk);
        $display("sent %0d sine/cosine words (specials, huge and ordinary angles), checked %0d",
                 words_sent, words_checked);
        if (fail_count == 0 && result_q.size() == 0)
            $display("fp32_sin_cos_unit: match");
        else
            $display("fp32_sin_cos_unit: mismatch");
        $finish;
    end

endmodule
